### hdl/ofdm_symbol_interleave_map_defines.svh
// Assertion macros for the symbol interleaver and cell mapper.
// Uses clk and arst_n from the including module; no other dependencies.
`ifndef OFDM_SYMBOL_INTERLEAVE_MAP_DEFINES_SVH
`define OFDM_SYMBOL_INTERLEAVE_MAP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define OSIM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define OSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OSIM_ASSERT_IMPL(lbl, ante, cons, msg)
`define OSIM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/osim_pkg.sv
// Shared constants, types and the constellation amplitude table for the
// symbol interleaver and cell mapper. No dependencies.
package osim_pkg;

	localparam int MAX_CARRIERS = 8192;
	localparam int SAMPLE_BITS  = 16;
	localparam int ADDR_W       = $clog2(MAX_CARRIERS);
	localparam int CNT_W        = ADDR_W + 1;
	localparam int CELL_W       = 6;
	localparam int LFSR_W       = 12;

	localparam int STEPS_2K = 2048;
	localparam int STEPS_8K = 8192;

	localparam logic [1:0] REG_FFT_MODE      = 2'd0;
	localparam logic [1:0] REG_CONSTELLATION = 2'd1;
	localparam logic [1:0] REG_CARRIERS      = 2'd2;

	localparam logic [1:0] CONS_QPSK  = 2'd0;
	localparam logic [1:0] CONS_QAM16 = 2'd1;
	localparam logic [1:0] CONS_QAM64 = 2'd2;

	localparam logic [CNT_W-1:0] CARRIERS_RESET = CNT_W'(1512);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] data;
	} tbl_wr_t;

	// level / sqrt(n) with 14 fraction bits, rounded to nearest
	function automatic logic [SAMPLE_BITS-1:0] level_amp(input logic [1:0] cons,
			input logic [2:0] lvl);
		logic [SAMPLE_BITS-1:0] amp;
		amp = '0;
		case (cons)
			CONS_QPSK: amp = SAMPLE_BITS'(11585);
			CONS_QAM16: amp = (lvl == 3'd1) ? SAMPLE_BITS'(5181) : SAMPLE_BITS'(15543);
			default: begin
				case (lvl)
					3'd1: amp = SAMPLE_BITS'(2528);
					3'd3: amp = SAMPLE_BITS'(7584);
					3'd5: amp = SAMPLE_BITS'(12641);
					3'd7: amp = SAMPLE_BITS'(17697);
					default: amp = '0;
				endcase
			end
		endcase
		return amp;
	endfunction

endpackage

### hdl/osim_addr_gen.sv
// 2k/8k interleaver address generator: walks the LFSR sequence and emits
// write requests that fill the permutation table. Depends on osim_pkg.
module osim_addr_gen (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic                       fft_mode,
	input  logic [osim_pkg::CNT_W-1:0] lim,
	output osim_pkg::tbl_wr_t          wr,
	output logic                       building,
	output logic [osim_pkg::CNT_W-1:0] fill
);

	logic                        build_q;
	logic [osim_pkg::ADDR_W-1:0] step_q;
	logic [osim_pkg::LFSR_W-1:0] lfsr_q;
	logic [osim_pkg::CNT_W-1:0]  fill_q;

	logic [osim_pkg::LFSR_W-1:0] lfsr_nxt;
	logic [osim_pkg::ADDR_W-1:0] r;
	logic [osim_pkg::ADDR_W-1:0] last_step;
	logic                        fb;

	always_comb begin
		fb = 1'b0;
		if (step_q < osim_pkg::ADDR_W'(2)) begin
			lfsr_nxt = '0;
		end else if (step_q == osim_pkg::ADDR_W'(2)) begin
			lfsr_nxt = osim_pkg::LFSR_W'(1);
		end else if (!fft_mode) begin
			fb = lfsr_q[0] ^ lfsr_q[3];
			lfsr_nxt = {2'b00, fb, lfsr_q[9:1]};
		end else begin
			fb = lfsr_q[0] ^ lfsr_q[1] ^ lfsr_q[4] ^ lfsr_q[6];
			lfsr_nxt = {fb, lfsr_q[11:1]};
		end

		r = '0;
		if (!fft_mode) begin
			r[4]  = lfsr_nxt[0];
			r[3]  = lfsr_nxt[1];
			r[9]  = lfsr_nxt[2];
			r[6]  = lfsr_nxt[3];
			r[2]  = lfsr_nxt[4];
			r[8]  = lfsr_nxt[5];
			r[1]  = lfsr_nxt[6];
			r[5]  = lfsr_nxt[7];
			r[7]  = lfsr_nxt[8];
			r[0]  = lfsr_nxt[9];
			r[10] = step_q[0];
		end else begin
			r[7]  = lfsr_nxt[0];
			r[1]  = lfsr_nxt[1];
			r[4]  = lfsr_nxt[2];
			r[2]  = lfsr_nxt[3];
			r[9]  = lfsr_nxt[4];
			r[6]  = lfsr_nxt[5];
			r[8]  = lfsr_nxt[6];
			r[10] = lfsr_nxt[7];
			r[0]  = lfsr_nxt[8];
			r[3]  = lfsr_nxt[9];
			r[11] = lfsr_nxt[10];
			r[5]  = lfsr_nxt[11];
			r[12] = step_q[0];
		end

		last_step = fft_mode ? osim_pkg::ADDR_W'(osim_pkg::STEPS_8K - 1)
		                     : osim_pkg::ADDR_W'(osim_pkg::STEPS_2K - 1);

		wr.we   = build_q && ({1'b0, r} < lim) && !fill_q[osim_pkg::CNT_W-1];
		wr.addr = fill_q[osim_pkg::ADDR_W-1:0];
		wr.data = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			build_q <= 1'b1;
			step_q  <= '0;
			lfsr_q  <= '0;
			fill_q  <= '0;
		end else if (restart) begin
			build_q <= 1'b1;
			step_q  <= '0;
			lfsr_q  <= '0;
			fill_q  <= '0;
		end else if (build_q) begin
			lfsr_q <= lfsr_nxt;
			step_q <= step_q + osim_pkg::ADDR_W'(1);
			if (wr.we)
				fill_q <= fill_q + osim_pkg::CNT_W'(1);
			if (step_q == last_step)
				build_q <= 1'b0;
		end
	end

	assign building = build_q;
	assign fill     = fill_q;

endmodule

### hdl/osim_mapper.sv
// QPSK / 16-QAM / 64-QAM cell mapper with registered result outputs.
// Depends on osim_pkg for the amplitude table and constellation codes.
module osim_mapper (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid,
	input  logic [osim_pkg::CELL_W-1:0]      cell_word,
	input  logic [osim_pkg::ADDR_W-1:0]      idx,
	input  logic                             last,
	input  logic [1:0]                       cons,
	output logic                             strobe,
	output logic signed [osim_pkg::SAMPLE_BITS-1:0] in_phase,
	output logic signed [osim_pkg::SAMPLE_BITS-1:0] quadrature,
	output logic [osim_pkg::ADDR_W-1:0]      carrier_index,
	output logic                             last_of_symbol
);

	logic [2:0]                       x_lvl, y_lvl;
	logic                             x_neg, y_neg;
	logic [1:0]                       cons_sel;
	logic [osim_pkg::SAMPLE_BITS-1:0] x_amp, y_amp;
	logic                             strobe_q;

	always_comb begin
		cons_sel = cons;
		case (cons)
			osim_pkg::CONS_QPSK: begin
				x_lvl = 3'd1;
				y_lvl = 3'd1;
				x_neg = cell_word[1];
				y_neg = cell_word[0];
			end
			osim_pkg::CONS_QAM16: begin
				x_lvl = cell_word[1] ? 3'd1 : 3'd3;
				y_lvl = cell_word[0] ? 3'd1 : 3'd3;
				x_neg = cell_word[3];
				y_neg = cell_word[2];
			end
			default: begin
				// code three maps as 64-QAM; Gray inner bit picks +/-1 around 2 or 6
				cons_sel = osim_pkg::CONS_QAM64;
				x_lvl = {~cell_word[3], 1'b0, 1'b1} +
					((cell_word[1] ^ cell_word[3]) ? 3'd0 : 3'd2);
				y_lvl = {~cell_word[2], 1'b0, 1'b1} +
					((cell_word[0] ^ cell_word[2]) ? 3'd0 : 3'd2);
				x_neg = cell_word[5];
				y_neg = cell_word[4];
			end
		endcase
		x_amp = osim_pkg::level_amp(cons_sel, x_lvl);
		y_amp = osim_pkg::level_amp(cons_sel, y_lvl);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= valid;
	end

	always_ff @(posedge clk) begin
		in_phase       <= x_neg ? -x_amp : x_amp;
		quadrature     <= y_neg ? -y_amp : y_amp;
		carrier_index  <= idx;
		last_of_symbol <= last;
	end

	assign strobe = strobe_q;

endmodule

### hdl/ofdm_symbol_interleave_map.sv
// Symbol interleaver + cell mapper. One carrier accepted per cycle while busy is low; the
// result for the previous symbol's carrier passes through the permutation table read,
// the cell store access and the mapper register; results cannot be stalled.
// After reset and after each fft_mode or carriers_in_use write, busy stays high while the
// address generator refills the table; the stream restarts and the first symbol produces no results.
`include "ofdm_symbol_interleave_map_defines.svh"
module ofdm_symbol_interleave_map (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [osim_pkg::CELL_W-1:0]      cell_bits,
	output logic                             strobe,
	output logic signed [osim_pkg::SAMPLE_BITS-1:0] in_phase,
	output logic signed [osim_pkg::SAMPLE_BITS-1:0] quadrature,
	output logic [osim_pkg::ADDR_W-1:0]      carrier_index,
	output logic                             last_of_symbol,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [osim_pkg::CNT_W-1:0]       cfg_data
);

	// configuration registers
	logic                       fft_q;
	logic [1:0]                 cons_q;
	logic [osim_pkg::CNT_W-1:0] carriers_q;

	logic [osim_pkg::ADDR_W-1:0] lim_m1;
	logic [osim_pkg::CNT_W-1:0]  lim;
	logic                        cfg_wr;
	logic                        restart;

	osim_pkg::tbl_wr_t           tbl_wr;
	logic                        building;
	logic [osim_pkg::CNT_W-1:0]  fill;

	// stream state
	logic [osim_pkg::ADDR_W-1:0] counter_q;
	logic                        parity_q;
	logic                        prev_valid_q;
	logic                        accept;

	// stage 1: table read returned
	logic                        valid_s1;
	logic                        outen_s1;
	logic [osim_pkg::ADDR_W-1:0] cnt_s1;
	logic                        par_s1;
	logic                        last_s1;
	logic                        short_s1;
	logic [osim_pkg::CELL_W-1:0] cell_s1;
	logic [osim_pkg::ADDR_W-1:0] perm_s1;
	logic [osim_pkg::ADDR_W-1:0] perm_eff;
	logic [osim_pkg::ADDR_W-1:0] mem_addr;

	// stage 2: cell store read returned
	logic                        valid_s2;
	logic [osim_pkg::ADDR_W-1:0] cnt_s2;
	logic                        last_s2;
	logic [osim_pkg::CELL_W-1:0] cell_s2;

	logic [osim_pkg::ADDR_W-1:0] perm_mem [osim_pkg::MAX_CARRIERS];
	logic [osim_pkg::CELL_W-1:0] cell_mem [2*osim_pkg::MAX_CARRIERS];

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr &&
		(cfg_index inside {osim_pkg::REG_FFT_MODE, osim_pkg::REG_CARRIERS});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_q      <= 1'b0;
			cons_q     <= osim_pkg::CONS_QPSK;
			carriers_q <= osim_pkg::CARRIERS_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				osim_pkg::REG_FFT_MODE:      fft_q      <= cfg_data[0];
				osim_pkg::REG_CONSTELLATION: cons_q     <= cfg_data[1:0];
				osim_pkg::REG_CARRIERS:      carriers_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero counts as one carrier, anything past the store size saturates
	always_comb begin
		if (carriers_q == '0)
			lim_m1 = '0;
		else if (carriers_q > osim_pkg::CNT_W'(osim_pkg::MAX_CARRIERS))
			lim_m1 = osim_pkg::ADDR_W'(osim_pkg::MAX_CARRIERS - 1);
		else
			lim_m1 = osim_pkg::ADDR_W'(carriers_q - osim_pkg::CNT_W'(1));
		lim = {1'b0, lim_m1} + osim_pkg::CNT_W'(1);
	end

	osim_addr_gen u_addr_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.fft_mode (fft_q),
		.lim      (lim),
		.wr       (tbl_wr),
		.building (building),
		.fill     (fill)
	);

	assign busy   = building;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q    <= '0;
			parity_q     <= 1'b0;
			prev_valid_q <= 1'b0;
		end else if (restart) begin
			counter_q    <= '0;
			parity_q     <= 1'b0;
			prev_valid_q <= 1'b0;
		end else if (accept) begin
			if (counter_q == lim_m1) begin
				counter_q    <= '0;
				parity_q     <= ~parity_q;
				prev_valid_q <= 1'b1;
			end else begin
				counter_q <= counter_q + osim_pkg::ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr.we)
			perm_mem[tbl_wr.addr] <= tbl_wr.data;
		perm_s1 <= perm_mem[counter_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1 && outen_s1;
		end
	end

	always_ff @(posedge clk) begin
		outen_s1 <= prev_valid_q;
		cnt_s1   <= counter_q;
		par_s1   <= parity_q;
		last_s1  <= (counter_q == lim_m1);
		short_s1 <= ({1'b0, counter_q} >= fill);
		cell_s1  <= cell_bits;
	end

	// entries past the generator's fill count read as zero.
	// Even halves are written permuted / read in order, odd halves the reverse,
	// so both accesses of one item share the same address.
	assign perm_eff = short_s1 ? '0 : perm_s1;
	assign mem_addr = par_s1 ? cnt_s1 : perm_eff;

	always_ff @(posedge clk) begin
		if (valid_s1)
			cell_mem[{par_s1, mem_addr}] <= cell_s1;
		cell_s2 <= cell_mem[{~par_s1, mem_addr}];
		cnt_s2  <= cnt_s1;
		last_s2 <= last_s1;
	end

	osim_mapper u_mapper (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid          (valid_s2),
		.cell_word      (cell_s2),
		.idx            (cnt_s2),
		.last           (last_s2),
		.cons           (cons_q),
		.strobe         (strobe),
		.in_phase       (in_phase),
		.quadrature     (quadrature),
		.carrier_index  (carrier_index),
		.last_of_symbol (last_of_symbol)
	);

	`OSIM_ASSERT_IMPL(a_counter_in_range, 1'b1, counter_q <= lim_m1, "carrier counter beyond symbol end")
	`OSIM_ASSERT_IMPL(a_build_clears_stream, busy, counter_q == '0 && !prev_valid_q, "stream live in build")
	`OSIM_ASSERT_IMPL(a_table_write_only_busy, tbl_wr.we, busy, "table written outside build")

endmodule

### bench/osim_carrier_checker.sv
// Carrier checker for ofdm_symbol_interleave_map: tracks register writes, predicts every
// mapped carrier from the accepted cell requests and compares it with the strobed output.
// Depends on osim_pkg only.
module osim_carrier_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic                                    busy,
	input  logic [osim_pkg::CELL_W-1:0]             cell_bits,
	input  logic                                    strobe,
	input  logic signed [osim_pkg::SAMPLE_BITS-1:0] in_phase,
	input  logic signed [osim_pkg::SAMPLE_BITS-1:0] quadrature,
	input  logic [osim_pkg::ADDR_W-1:0]             carrier_index,
	input  logic                                    last_of_symbol,
	input  logic                                    cfg_valid,
	input  logic                                    cfg_ready,
	input  logic [1:0]                              cfg_index,
	input  logic [osim_pkg::CNT_W-1:0]              cfg_data,
	output int unsigned                             mismatches,
	output int unsigned                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [osim_pkg::SAMPLE_BITS-1:0] i_val;
		logic signed [osim_pkg::SAMPLE_BITS-1:0] q_val;
		logic [osim_pkg::ADDR_W-1:0]             index;
		logic                                    last;
	} carrier_t;

	carrier_t expected_carriers [$];

	logic                        fft_8k;
	logic [1:0]                  cons_sel;
	logic [osim_pkg::CNT_W-1:0]  carriers_cfg;
	logic [osim_pkg::ADDR_W-1:0] perm_table [osim_pkg::MAX_CARRIERS];
	logic [osim_pkg::CELL_W-1:0] cell_mem [2*osim_pkg::MAX_CARRIERS];
	int unsigned                 carrier_pos;
	logic                        odd_symbol;
	logic                        have_symbol;

	function automatic int unsigned symbol_len();
		int unsigned n;
		n = carriers_cfg;
		if (n == 0) n = 1;
		if (n > osim_pkg::MAX_CARRIERS) n = osim_pkg::MAX_CARRIERS;
		return n;
	endfunction

	// address generator: LFSR, bit shuffle, toggle on top, keep what fits the symbol
	function automatic void build_perm();
		int unsigned lim, kept, steps, i;
		logic [osim_pkg::LFSR_W-1:0] lfsr;
		logic [osim_pkg::ADDR_W-1:0] addr;
		logic fb;
		lim = symbol_len();
		kept = 0;
		steps = fft_8k ? osim_pkg::STEPS_8K : osim_pkg::STEPS_2K;
		foreach (perm_table[k]) perm_table[k] = '0;
		lfsr = '0;
		for (i = 0; i < steps; i++) begin
			if (i < 2) begin
				lfsr = '0;
			end else if (i == 2) begin
				lfsr = osim_pkg::LFSR_W'(1);
			end else if (!fft_8k) begin
				fb = lfsr[0] ^ lfsr[3];
				lfsr = {2'b00, fb, lfsr[9:1]};
			end else begin
				fb = lfsr[0] ^ lfsr[1] ^ lfsr[4] ^ lfsr[6];
				lfsr = {fb, lfsr[11:1]};
			end
			if (!fft_8k)
				addr = {2'b00, i[0], lfsr[2], lfsr[5], lfsr[8], lfsr[3], lfsr[7],
					lfsr[0], lfsr[1], lfsr[4], lfsr[6], lfsr[9]};
			else
				addr = {i[0], lfsr[10], lfsr[7], lfsr[4], lfsr[6], lfsr[0], lfsr[5],
					lfsr[11], lfsr[2], lfsr[9], lfsr[3], lfsr[1], lfsr[8]};
			if (addr < lim && kept < osim_pkg::MAX_CARRIERS) begin
				perm_table[kept] = addr;
				kept++;
			end
		end
	endfunction

	function automatic void restart_stream();
		carrier_pos = 0;
		odd_symbol = 1'b0;
		have_symbol = 1'b0;
		build_perm();
	endfunction

	// level * 2^F / sqrt(norm), rounded half up, found exactly by bisection
	function automatic logic [osim_pkg::SAMPLE_BITS-1:0] amplitude(int unsigned level,
			int unsigned norm, logic neg);
		longint unsigned bound, lo, hi, mid, t;
		bound = longint'(level) * level * 4;
		bound = bound << (2 * (osim_pkg::SAMPLE_BITS - 2));
		lo = 0;
		hi = 64'd1 << osim_pkg::SAMPLE_BITS;
		while (hi - lo > 1) begin
			mid = lo + (hi - lo) / 2;
			t = 2 * mid - 1;
			if (t * t * norm <= bound) lo = mid;
			else hi = mid;
		end
		return neg ? osim_pkg::SAMPLE_BITS'(0 - lo) : osim_pkg::SAMPLE_BITS'(lo);
	endfunction

	function automatic carrier_t map_cell(logic [osim_pkg::CELL_W-1:0] b, int unsigned idx,
			logic last);
		carrier_t r;
		int unsigned lx, ly;
		r.index = osim_pkg::ADDR_W'(idx);
		r.last = last;
		case (cons_sel)
			osim_pkg::CONS_QPSK: begin
				r.i_val = amplitude(1, 2, b[1]);
				r.q_val = amplitude(1, 2, b[0]);
			end
			osim_pkg::CONS_QAM16: begin
				r.i_val = amplitude(b[1] ? 1 : 3, 10, b[3]);
				r.q_val = amplitude(b[0] ? 1 : 3, 10, b[2]);
			end
			default: begin
				// Gray coded 64-QAM; the unused code three maps here too
				lx = b[3] ? 2 : 6;
				ly = b[2] ? 2 : 6;
				lx = (b[1] ^ b[3]) ? lx - 1 : lx + 1;
				ly = (b[0] ^ b[2]) ? ly - 1 : ly + 1;
				r.i_val = amplitude(lx, 42, b[5]);
				r.q_val = amplitude(ly, 42, b[4]);
			end
		endcase
		return r;
	endfunction

	// even symbols land permuted and leave in order, odd ones the other way round
	function automatic void accept_cell(logic [osim_pkg::CELL_W-1:0] cell_word);
		int unsigned lim, c, raddr, waddr;
		logic prev;
		lim = symbol_len();
		c = carrier_pos;
		if (c >= lim) c = lim - 1;
		prev = ~odd_symbol;
		if (have_symbol) begin
			raddr = prev ? perm_table[c] : c;
			expected_carriers.push_back(map_cell(
				cell_mem[(prev ? osim_pkg::MAX_CARRIERS : 0) + raddr], c, c == lim - 1));
		end
		waddr = odd_symbol ? c : perm_table[c];
		cell_mem[(odd_symbol ? osim_pkg::MAX_CARRIERS : 0) + waddr] = cell_word;
		c++;
		if (c >= lim) begin
			c = 0;
			odd_symbol = prev;
			have_symbol = 1'b1;
		end
		carrier_pos = c;
	endfunction

	function automatic void apply_write(logic [1:0] idx, logic [osim_pkg::CNT_W-1:0] val);
		case (idx)
			osim_pkg::REG_FFT_MODE: begin
				fft_8k = val[0];
				restart_stream();
			end
			osim_pkg::REG_CONSTELLATION: cons_sel = val[1:0];
			osim_pkg::REG_CARRIERS: begin
				carriers_cfg = val;
				restart_stream();
			end
			default: ;
		endcase
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		$display("%0t ns mismatch: %s", $realtime, what);
	endtask

	task automatic check_carrier();
		carrier_t want;
		if (expected_carriers.size() == 0) begin
			note_mismatch($sformatf("carrier %0d strobed with nothing pending", carrier_index));
		end else begin
			want = expected_carriers.pop_front();
			if (in_phase !== want.i_val)
				note_mismatch($sformatf("carrier %0d in_phase %0d, want %0d",
					want.index, in_phase, want.i_val));
			if (quadrature !== want.q_val)
				note_mismatch($sformatf("carrier %0d quadrature %0d, want %0d",
					want.index, quadrature, want.q_val));
			if (carrier_index !== want.index)
				note_mismatch($sformatf("carrier_index %0d, want %0d", carrier_index, want.index));
			if (last_of_symbol !== want.last)
				note_mismatch($sformatf("carrier %0d last_of_symbol %b, want %b",
					want.index, last_of_symbol, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_8k = 1'b0;
			cons_sel = osim_pkg::CONS_QPSK;
			carriers_cfg = osim_pkg::CARRIERS_RESET;
			foreach (cell_mem[k]) cell_mem[k] = '0;
			expected_carriers.delete();
			restart_stream();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
			if (strobe) check_carrier();
			if (start && !busy) accept_cell(cell_bits);
			outstanding <= expected_carriers.size();
		end
	end

endmodule

### bench/ofdm_symbol_interleave_map_tb.sv
// Testbench top for ofdm_symbol_interleave_map: clock, reset, cell requests and register
// writes with random idling; osim_carrier_checker (bench) does the prediction and compares.
// Depends on osim_pkg and the RTL.
module ofdm_symbol_interleave_map_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]  CONS_CODE3   = 2'd3;
	localparam int unsigned RUN_LIMIT    = 4_000_000;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned RANDOM_ITEMS = 900;
	localparam int unsigned SAT_ITEMS    = 24;

	logic                                    clk;
	logic                                    arst_n;
	logic                                    start;
	logic                                    busy;
	logic [osim_pkg::CELL_W-1:0]             cell_bits;
	logic                                    strobe;
	logic signed [osim_pkg::SAMPLE_BITS-1:0] in_phase;
	logic signed [osim_pkg::SAMPLE_BITS-1:0] quadrature;
	logic [osim_pkg::ADDR_W-1:0]             carrier_index;
	logic                                    last_of_symbol;
	logic                                    cfg_valid;
	logic                                    cfg_ready;
	logic [1:0]                              cfg_index;
	logic [osim_pkg::CNT_W-1:0]              cfg_data;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count;

	ofdm_symbol_interleave_map DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cell_bits(cell_bits),
		.strobe(strobe),
		.in_phase(in_phase),
		.quadrature(quadrature),
		.carrier_index(carrier_index),
		.last_of_symbol(last_of_symbol),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	osim_carrier_checker carrier_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cell_bits(cell_bits),
		.strobe(strobe),
		.in_phase(in_phase),
		.quadrature(quadrature),
		.carrier_index(carrier_index),
		.last_of_symbol(last_of_symbol),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic feed_cell(input logic [osim_pkg::CELL_W-1:0] value, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cell_bits <= value;
		do @(posedge clk); while (busy);
	endtask

	// hold requests until every predicted carrier is out, then let the pipe empty
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [osim_pkg::CNT_W-1:0] val);
		while (busy) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned n, cur_len, random_sent;
		logic steady;
		arst_n <= 1'b0;
		start <= 1'b0;
		cell_bits <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= osim_pkg::REG_FFT_MODE;
		cfg_data <= '0;
		random_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero carriers count as one: each request after the first returns the previous cell
		write_reg(osim_pkg::REG_CARRIERS, '0);
		feed_cell(6'h3F, 0);
		feed_cell(6'h00, 0);
		feed_cell(6'h01, 1);
		feed_cell(6'h02, 0);
		drain_results();
		write_reg(osim_pkg::REG_CONSTELLATION, osim_pkg::CNT_W'(osim_pkg::CONS_QAM16));
		feed_cell(6'h05, 0);
		feed_cell(6'h0A, 0);
		feed_cell(6'h0F, 2);
		drain_results();
		write_reg(osim_pkg::REG_CONSTELLATION, osim_pkg::CNT_W'(osim_pkg::CONS_QAM64));
		feed_cell(6'h00, 0);
		feed_cell(6'h3F, 0);
		feed_cell(6'h2A, 0);
		feed_cell(6'h15, 3);
		feed_cell(6'h09, 0);
		drain_results();
		write_reg(osim_pkg::REG_CONSTELLATION, osim_pkg::CNT_W'(CONS_CODE3));
		feed_cell(6'h36, 0);
		feed_cell(6'h1B, 0);
		drain_results();
		write_reg(osim_pkg::REG_FFT_MODE, osim_pkg::CNT_W'(1));
		write_reg(osim_pkg::REG_CARRIERS, osim_pkg::CNT_W'(1));
		write_reg(osim_pkg::REG_CONSTELLATION, osim_pkg::CNT_W'(osim_pkg::CONS_QPSK));
		feed_cell(6'h3C, 0);
		feed_cell(6'h03, 0);
		feed_cell(6'h30, 0);
		drain_results();

		// oversized count saturates to a full 8k symbol, so nothing comes out yet
		write_reg(osim_pkg::REG_CARRIERS, '1);
		write_reg(osim_pkg::REG_CONSTELLATION, osim_pkg::CNT_W'(osim_pkg::CONS_QAM64));
		repeat (SAT_ITEMS) feed_cell(osim_pkg::CELL_W'($urandom), idle_len());
		drain_results();
		write_reg(osim_pkg::REG_CARRIERS, osim_pkg::CNT_W'(12));

		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				// constellation only: the stream runs on across the write
				n = $urandom_range(1, 40);
			end else begin
				if ($urandom_range(0, 2) != 0)
					write_reg(osim_pkg::REG_FFT_MODE, osim_pkg::CNT_W'($urandom_range(0, 1)));
				cur_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) :
					$urandom_range(1, 40);
				write_reg(osim_pkg::REG_CARRIERS, osim_pkg::CNT_W'(cur_len));
				n = cur_len * $urandom_range(1, 3) + $urandom_range(0, cur_len);
			end
			if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
			write_reg(osim_pkg::REG_CONSTELLATION, osim_pkg::CNT_W'($urandom_range(0, 3)));
			steady = ($urandom_range(0, 4) == 0);
			repeat (n) begin
				feed_cell(osim_pkg::CELL_W'($urandom), steady ? 0 : idle_len());
				random_sent++;
				if ($urandom_range(0, 150) == 0) drain_results();
			end
			drain_results();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
